FILE: rtl/core/stbtc_pkg.sv
// shared types, constants and helpers for the stereo two-band tone control
package stbtc_pkg;

    localparam int SW = 16;

    // configuration register indexes
    localparam logic [0:0] REG_TREBLE = 1'b0;
    localparam logic [0:0] REG_BASS   = 1'b1;

    // fixed shelf coefficients
    localparam logic signed [SW-1:0] TRE_A0 = 16'sd25062;
    localparam logic signed [SW-1:0] TRE_A1 = 16'sd3595;
    localparam logic signed [SW-1:0] TRE_A2 = 16'sd516;
    localparam logic signed [SW-1:0] TRE_K  = 16'sd9598;
    localparam logic signed [SW-1:0] TRE_G0 = 16'sd23170;
    localparam logic signed [SW-1:0] BAS_A0 = 16'sd30977;
    localparam logic signed [SW-1:0] BAS_A1 = 16'sd883;
    localparam logic signed [SW-1:0] BAS_A2 = 16'sd25;
    localparam logic signed [SW-1:0] BAS_K  = 16'sd13573;
    localparam logic signed [SW-1:0] HALF   = 16'sd16384;

    // accumulator width: sums of a few 16x17 products plus rounding headroom
    localparam int AW = 40;

    typedef logic signed [SW-1:0] samp_t;
    typedef logic signed [AW-1:0] acc_t;

    // handshake from the sequencer to the serial multiply-accumulate unit
    typedef struct packed {
        logic             start;
        logic             clear;
        logic signed [17:0] mcand;
        logic signed [17:0] mplier;
    } mac_cmd_t;

    typedef struct packed {
        logic done;
        acc_t acc;
    } mac_rsp_t;

    function automatic samp_t sat_acc(input acc_t v);
        if (v > acc_t'(32767))       return 16'sh7fff;
        else if (v < acc_t'(-32768)) return 16'sh8000;
        else                         return v[SW-1:0];
    endfunction

endpackage

FILE: rtl/core/stbtc_smac.sv
// bit-serial multiply-accumulate unit, one multiplier bit per cycle
module stbtc_smac (
    input  logic               clk,
    input  logic               rst_n,
    input  stbtc_pkg::mac_cmd_t cmd,
    output stbtc_pkg::mac_rsp_t rsp
);
    import stbtc_pkg::*;

    localparam int MB = 18;

    acc_t             acc_reg, acc_next;
    acc_t             mc_reg, mc_next;
    logic [MB-1:0]    mp_reg, mp_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            if (cmd.clear)
                acc_next = '0;
            mc_next   = acc_t'(cmd.mcand);
            mp_next   = cmd.mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of the multiplier carries negative weight
            if (mp_reg[0])
            begin
                if (cnt_reg == 5'(MB-1))
                    acc_next = acc_reg - mc_reg;
                else
                    acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(MB-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg <= mc_next;
        mp_reg <= mp_next;
    end

    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;
endmodule

FILE: rtl/core/stbtc_seq.sv
// microcode sequencer: coefficient setup and per-sample shelf filtering
module stbtc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  stbtc_pkg::samp_t    left_x,
    input  stbtc_pkg::samp_t    right_x,
    input  stbtc_pkg::samp_t    treble,
    input  stbtc_pkg::samp_t    bass,
    output logic                fin,
    output stbtc_pkg::samp_t    left_y,
    output stbtc_pkg::samp_t    right_y,
    output stbtc_pkg::mac_cmd_t cmd,
    input  stbtc_pkg::mac_rsp_t rsp
);
    import stbtc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT = 3'b100
    } st_t;

    // micro-op indexes
    localparam logic [4:0] OP_TG    = 5'd0;  // g_t = t*K
    localparam logic [4:0] OP_TA3   = 5'd1;  // a3 = g*g
    localparam logic [4:0] OP_TA4   = 5'd2;  // 23170*g
    localparam logic [4:0] OP_BG    = 5'd3;  // g_b = b*K
    localparam logic [4:0] OP_BA5   = 5'd4;  // g_b*g_b
    localparam logic [4:0] OP_V1A   = 5'd5;  // a0*s0
    localparam logic [4:0] OP_V1B   = 5'd6;  // + a1*(x-s1)
    localparam logic [4:0] OP_V2A   = 5'd7;  // s1*2^15
    localparam logic [4:0] OP_V2B   = 5'd8;  // + a1*s0
    localparam logic [4:0] OP_V2C   = 5'd9;  // + a2*(x-s1)
    localparam logic [4:0] OP_YA    = 5'd10; // a3*x
    localparam logic [4:0] OP_YB    = 5'd11; // + a4*v1
    localparam logic [4:0] OP_YC    = 5'd12; // + a5*v2

    st_t          st_reg, st_next;
    logic [4:0]   op_reg, op_next;
    logic [1:0]   flt_reg, flt_next;    // 0 tre l, 1 tre r, 2 bas l, 3 bas r
    logic         fin_reg, fin_next;
    samp_t        mem_reg [8];
    samp_t        ta3_reg, ta4_reg, ta5_reg, bg_reg, ba5_reg, tg_reg;
    samp_t        v1_reg, v2_reg, xl_reg, xr_reg;

    acc_t         rnd_acc, y_acc;
    samp_t        q15, rnd15, yv;
    samp_t        s0, s1, x_cur, a0, a1, a2, a3, a4, a5;
    logic [2:0]   base;
    logic signed [16:0] xd;
    logic signed [17:0] ta4_w, ba5_w;

    assign base  = {flt_reg, 1'b0};
    assign s0    = mem_reg[base];
    assign s1    = mem_reg[base + 3'd1];
    assign x_cur = flt_reg[0] ? xr_reg : xl_reg;
    assign xd    = 17'(x_cur) - 17'(s1);
    assign a0 = flt_reg[1] ? BAS_A0 : TRE_A0;
    assign a1 = flt_reg[1] ? BAS_A1 : TRE_A1;
    assign a2 = flt_reg[1] ? BAS_A2 : TRE_A2;
    assign a3 = flt_reg[1] ? HALF   : ta3_reg;
    assign a4 = flt_reg[1] ? bg_reg : ta4_reg;
    assign a5 = flt_reg[1] ? ba5_reg : ta5_reg;

    // floor shift and saturate, round half up and saturate
    assign q15   = sat_acc(rsp.acc >>> 15);
    assign rnd_acc = rsp.acc + acc_t'(16384);
    assign rnd15 = sat_acc(rnd_acc >>> 15);
    assign y_acc = (rsp.acc <<< 1) + acc_t'(16384);
    assign yv    = sat_acc(y_acc >>> 15);
    assign ta4_w = 18'(q15) - 18'(ta3_reg);
    assign ba5_w = 18'(q15 >>> 1) + 18'(bg_reg);

    always_comb
    begin
        cmd.start  = 1'b0;
        cmd.clear  = 1'b1;
        cmd.mcand  = '0;
        cmd.mplier = '0;
        if (st_reg == S_ISSUE)
        begin
            cmd.start = 1'b1;
            case (op_reg)
                OP_TG:  begin cmd.mcand = 18'(treble); cmd.mplier = 18'(TRE_K); end
                OP_TA3: begin cmd.mcand = 18'(tg_reg); cmd.mplier = 18'(tg_reg); end
                OP_TA4: begin cmd.mcand = 18'(TRE_G0); cmd.mplier = 18'(tg_reg); end
                OP_BG:  begin cmd.mcand = 18'(bass);   cmd.mplier = 18'(BAS_K); end
                OP_BA5: begin cmd.mcand = 18'(bg_reg); cmd.mplier = 18'(bg_reg); end
                OP_V1A: begin cmd.mcand = 18'(a0); cmd.mplier = 18'(s0); end
                OP_V1B: begin cmd.clear = 1'b0; cmd.mcand = 18'(a1); cmd.mplier = 18'(xd); end
                OP_V2A: begin cmd.mcand = 18'(s1); cmd.mplier = 18'sd32768; end
                OP_V2B: begin cmd.clear = 1'b0; cmd.mcand = 18'(a1); cmd.mplier = 18'(s0); end
                OP_V2C: begin cmd.clear = 1'b0; cmd.mcand = 18'(a2); cmd.mplier = 18'(xd); end
                OP_YA:  begin cmd.mcand = 18'(a3); cmd.mplier = 18'(x_cur); end
                OP_YB:  begin cmd.clear = 1'b0; cmd.mcand = 18'(a4); cmd.mplier = 18'(v1_reg); end
                OP_YC:  begin cmd.clear = 1'b0; cmd.mcand = 18'(a5); cmd.mplier = 18'(v2_reg); end
                default: cmd.start = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        st_next  = st_reg;
        op_next  = op_reg;
        flt_next = flt_reg;
        fin_next = 1'b0;
        case (st_reg)
            S_IDLE:
                if (go)
                begin
                    st_next  = S_ISSUE;
                    op_next  = OP_TG;
                    flt_next = 2'd0;
                end
            S_ISSUE: st_next = S_WAIT;
            S_WAIT:
                if (rsp.done)
                begin
                    st_next = S_ISSUE;
                    if (op_reg == OP_YC)
                    begin
                        op_next  = OP_V1A;
                        flt_next = flt_reg + 2'd1;
                        if (flt_reg == 2'd3)
                        begin
                            st_next  = S_IDLE;
                            fin_next = 1'b1;
                        end
                    end
                    else
                        op_next = op_reg + 5'd1;
                end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            op_reg  <= OP_TG;
            flt_reg <= '0;
            fin_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                mem_reg[i] <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            op_reg  <= op_next;
            flt_reg <= flt_next;
            fin_reg <= fin_next;
            // both states move together once v2 is known, v2 needs the old s0
            if (st_reg == S_WAIT && rsp.done && op_reg == OP_V2C)
            begin
                mem_reg[base] <=
                    sat_acc((acc_t'(v1_reg) <<< 1) - acc_t'(s0));
                mem_reg[base + 3'd1] <=
                    sat_acc((acc_t'(rnd15) <<< 1) - acc_t'(s1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && go)
        begin
            xl_reg <= left_x;
            xr_reg <= right_x;
        end
        if (st_reg == S_WAIT && rsp.done)
        begin
            case (op_reg)
                OP_TG:  tg_reg <= sat_acc(acc_t'(q15) + acc_t'(TRE_G0));
                OP_TA3:
                begin
                    ta3_reg <= q15;
                    ta5_reg <= sat_acc(acc_t'(HALF) - acc_t'(q15));
                end
                OP_TA4: ta4_reg <= sat_acc(acc_t'(ta4_w) <<< 1);
                OP_BG:  bg_reg  <= q15;
                OP_BA5: ba5_reg <= sat_acc(acc_t'(ba5_w));
                OP_V1B: v1_reg  <= rnd15;
                OP_V2C: v2_reg  <= rnd15;
                OP_YC:
                begin
                    if (flt_reg[0]) xr_reg <= yv;
                    else            xl_reg <= yv;
                end
                default: ;
            endcase
        end
    end

    assign fin     = fin_reg;
    assign left_y  = xl_reg;
    assign right_y = xr_reg;
endmodule

FILE: rtl/core/stereo_two_band_shelf_tone_control.sv
// stereo treble/bass shelf tone control top level
//
//  group   dir  payload
//  s_axis  in   tdata[15:0] left_in, tdata[31:16] right_in
//  m_axis  out  tdata[15:0] left_out, tdata[31:16] right_out
//  cfg     in   cfg_index 0 treble_level, 1 bass_level; cfg_data[15:0]
//
// one word runs from accept to result valid through 37 products
// (5 coefficient products, then 8 per filter stage over 4 stages)
// in the one bit-serial multiplier
// reset clears filter state and levels to zero; no clearing pass
// the result sits in an output register; a new word is taken once the
// previous result has been handed over, so an output stall holds the input
module stereo_two_band_shelf_tone_control (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [2*stbtc_pkg::SW-1:0]  s_axis_tdata,   // left_in, right_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [2*stbtc_pkg::SW-1:0]  m_axis_tdata,   // left_out, right_out
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [stbtc_pkg::SW-1:0]    cfg_data
);
    import stbtc_pkg::*;

    samp_t    tre_reg, bas_reg, yl_reg, yr_reg, yl, yr;
    logic     busy_reg, ov_reg, fin, go;
    mac_cmd_t cmd;
    mac_rsp_t rsp;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg && !ov_reg;
    assign go            = s_axis_tvalid && s_axis_tready;

    stbtc_smac u_mac (.clk, .rst_n, .cmd, .rsp);

    stbtc_seq u_seq (
        .clk, .rst_n, .go,
        .left_x  (s_axis_tdata[SW-1:0]),
        .right_x (s_axis_tdata[2*SW-1:SW]),
        .treble  (tre_reg),
        .bass    (bas_reg),
        .fin,
        .left_y  (yl),
        .right_y (yr),
        .cmd, .rsp
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tre_reg  <= '0;
            bas_reg  <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_TREBLE) tre_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_BASS)   bas_reg <= cfg_data;
            if (go)
                busy_reg <= 1'b1;
            if (fin)
            begin
                busy_reg <= 1'b0;
                ov_reg   <= 1'b1;
            end
            else if (ov_reg && m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            yl_reg <= yl;
            yr_reg <= yr;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {yr_reg, yl_reg};
endmodule
